[hw/rtl/tts_pkg.sv]
// Shared types and constants of the timer table scheduler.
// No dependencies.
package tts_pkg;

	localparam int MAX_TIMERS_DEF = 16;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_CLR_ID  = 2'd1,
		CMD_CLR_ALL = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ASSIGNED = 2'd0,
		KIND_FULL     = 2'd1,
		KIND_FIRED    = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	typedef struct packed {
		cmd_t               cmd;
		logic        [31:0] due_time;
		logic signed [31:0] period;
		logic        [31:0] now;
		logic        [31:0] target_id;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] timer_id;
		logic        last;
		logic        table_empty;
	} out_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] due;
		logic [31:0] period;
	} entry_t;

	// handshake between command queue and executor
	typedef struct packed {
		logic valid;
		in_t  data;
	} cmdq_t;

endpackage

[hw/rtl/tts_front.sv]
// Command front end: two-entry queue that takes input words.
// Depends on tts_pkg.
module tts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tts_pkg::in_t      in_data,
	output tts_pkg::cmdq_t    q_head,
	input  logic              q_pop
);

	tts_pkg::in_t fifo_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign in_ready     = (cnt_q != 2'd2);
	assign push         = in_valid && in_ready;
	assign pop          = q_pop && (cnt_q != 2'd0);
	assign q_head.valid = (cnt_q != 2'd0);
	assign q_head.data  = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[hw/rtl/tts_back.sv]
// Command executor: slot memory, scan sequencer and result register.
// Depends on tts_pkg.
module tts_back #(
	parameter int MAX_TIMERS = tts_pkg::MAX_TIMERS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tts_pkg::cmdq_t  q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output tts_pkg::out_t   out_data
);

	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P1_RD,
		ST_P1_PROC,
		ST_P2_RD,
		ST_P2_PROC
	} state_t;

	state_t               state_q;
	tts_pkg::in_t         cur_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        r_q;
	logic [CW-1:0]        w_q;
	logic [CW-1:0]        surv_q;
	logic [31:0]          last_id_q;
	tts_pkg::entry_t      mem [MAX_TIMERS];
	tts_pkg::entry_t      rd_q;
	logic                 out_valid_q;
	tts_pkg::out_t        out_q;

	logic                 out_free;
	logic                 is_tick;
	logic                 oneshot;
	logic                 fire;
	logic                 keep;
	logic                 stall;
	logic                 full;
	logic                 mem_re;
	logic                 mem_we;
	logic [IW-1:0]        mem_waddr;
	tts_pkg::entry_t      mem_wdata;
	logic [31:0]          next_id;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign full      = (cnt_q == CW'(MAX_TIMERS));
	assign next_id   = last_id_q + 32'd1;
	assign is_tick   = (cur_q.cmd == tts_pkg::CMD_TICK);
	assign oneshot   = (rd_q.period == 32'd0) || (rd_q.period == 32'hFFFF_FFFF);
	assign fire      = is_tick && (rd_q.due <= cur_q.now);
	assign keep      = is_tick ? !(fire && oneshot) : (rd_q.id != cur_q.target_id);
	assign stall     = fire && !out_free;
	assign mem_re    = ((state_q == ST_P1_RD) || (state_q == ST_P2_RD)) && (r_q != cnt_q);
	assign q_pop     = (state_q == ST_IDLE) && q_head.valid && out_free;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = w_q[IW-1:0];
		mem_wdata = rd_q;
		if (state_q == ST_IDLE) begin
			mem_we           = q_pop && (q_head.data.cmd == tts_pkg::CMD_ADD) && !full;
			mem_waddr        = cnt_q[IW-1:0];
			mem_wdata.id     = next_id;
			mem_wdata.due    = q_head.data.due_time;
			mem_wdata.period = q_head.data.period;
		end else if (state_q == ST_P2_PROC) begin
			mem_we = keep && !stall;
			if (fire) begin
				mem_wdata.due = rd_q.due + rd_q.period;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[r_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			r_q         <= '0;
			w_q         <= '0;
			surv_q      <= '0;
			last_id_q   <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			out_q       <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						cur_q  <= q_head.data;
						r_q    <= '0;
						w_q    <= '0;
						surv_q <= '0;
						case (q_head.data.cmd)
							tts_pkg::CMD_ADD: begin
								out_valid_q       <= 1'b1;
								out_q.last        <= 1'b1;
								out_q.table_empty <= 1'b0;
								if (full) begin
									out_q.kind     <= tts_pkg::KIND_FULL;
									out_q.timer_id <= '0;
								end else begin
									out_q.kind     <= tts_pkg::KIND_ASSIGNED;
									out_q.timer_id <= next_id;
									last_id_q      <= next_id;
									cnt_q          <= cnt_q + CW'(1);
								end
							end
							tts_pkg::CMD_CLR_ALL: begin
								cnt_q             <= '0;
								out_valid_q       <= 1'b1;
								out_q.kind        <= tts_pkg::KIND_DONE;
								out_q.timer_id    <= '0;
								out_q.last        <= 1'b1;
								out_q.table_empty <= 1'b1;
							end
							tts_pkg::CMD_CLR_ID: begin
								state_q <= ST_P2_RD;
							end
							default: begin
								state_q <= ST_P1_RD;
							end
						endcase
					end
				end
				ST_P1_RD: begin
					if (r_q == cnt_q) begin
						r_q     <= '0;
						state_q <= ST_P2_RD;
					end else begin
						state_q <= ST_P1_PROC;
					end
				end
				ST_P1_PROC: begin
					surv_q  <= surv_q + CW'(keep);
					r_q     <= r_q + CW'(1);
					state_q <= ST_P1_RD;
				end
				ST_P2_RD: begin
					if (r_q == cnt_q) begin
						if (out_free) begin
							cnt_q             <= w_q;
							out_valid_q       <= 1'b1;
							out_q.kind        <= tts_pkg::KIND_DONE;
							out_q.timer_id    <= '0;
							out_q.last        <= 1'b1;
							out_q.table_empty <= (w_q == '0);
							state_q           <= ST_IDLE;
						end
					end else begin
						state_q <= ST_P2_PROC;
					end
				end
				ST_P2_PROC: begin
					if (!stall) begin
						if (fire) begin
							out_valid_q       <= 1'b1;
							out_q.kind        <= tts_pkg::KIND_FIRED;
							out_q.timer_id    <= rd_q.id;
							out_q.last        <= 1'b0;
							out_q.table_empty <= (surv_q == '0);
						end
						if (keep) begin
							w_q <= w_q + CW'(1);
						end
						r_q     <= r_q + CW'(1);
						state_q <= ST_P2_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/timer_table_scheduler.sv]
// Timer table scheduler top level: command queue feeding the executor.
// Depends on tts_pkg, tts_front, tts_back.
//
//  channel | handshake             | word
//  --------+-----------------------+-----------------------
//  input   | in_valid / in_ready   | in_data  (tts_pkg::in_t)
//  output  | out_valid / out_ready | out_data (tts_pkg::out_t)
//
// Add and clear-all: one result, registered as the queue head is popped.
// Clear by id makes one pass over the stored timers, tick two; each pass
// visits a read state and a process state per slot, as the slot memory has
// a registered read (tick counts survivors first, so every result knows
// table_empty, then compacts and fires). Reset empties the table at once;
// the slot memory itself is never cleared, only the fill count. A stalled
// output holds the scan; the two-entry queue takes words while it has room.
module timer_table_scheduler #(
	parameter int MAX_TIMERS = tts_pkg::MAX_TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tts_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tts_pkg::out_t out_data
);

	tts_pkg::cmdq_t q_head;
	logic           q_pop;

	// front: buffers up to two commands so the host is not held at once while a tick scans
	tts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	// back: owns the table and drives the result register
	tts_back #(
		.MAX_TIMERS (MAX_TIMERS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[hw/rtl/tts_checker.sv]
// Port-level checks on the timer table scheduler, bound to the top level.
// Depends on tts_pkg.
module tts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input tts_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input tts_pkg::out_t out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("command word changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == tts_pkg::KIND_FIRED) |-> !out_data.last)
		else $error("fired word marked last");

	a_other_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind != tts_pkg::KIND_FIRED) |-> out_data.last)
		else $error("closing word not marked last");

	a_assigned_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == tts_pkg::KIND_ASSIGNED) |-> !out_data.table_empty)
		else $error("table empty after add");

endmodule

bind timer_table_scheduler tts_checker u_tts_checker (.*);

[sim/timer_table_scheduler_test.sv]
// Testbench for the timer table scheduler: random and directed commands with
// a table-tracking scoreboard class. Depends on tts_pkg and timer_table_scheduler.
`timescale 1ns / 100ps

module timer_table_scheduler_test;

	localparam int SLOTS = tts_pkg::MAX_TIMERS_DEF;
	localparam int RANDOM_WORDS = 290;
	localparam longint CYCLE_LIMIT = 2000000;

	// Scoreboard: keeps its own copy of the timer table and the queue of
	// results still owed by the block.
	class timer_scoreboard;
		logic [31:0] ent_id [$];
		logic [31:0] ent_due [$];
		logic [31:0] ent_per [$];
		logic [31:0] id_counter;
		tts_pkg::out_t owed [$];
		int errors;
		int results_seen;
		int fires_seen;

		function new();
			id_counter = '0;
			errors = 0;
			results_seen = 0;
			fires_seen = 0;
		endfunction

		function void note_command(tts_pkg::in_t w);
			tts_pkg::out_t r [$];
			tts_pkg::out_t o;
			logic [31:0] nid [$];
			logic [31:0] ndue [$];
			logic [31:0] nper [$];
			bit keep;
			case (w.cmd)
				tts_pkg::CMD_ADD: begin
					if (ent_id.size() >= SLOTS) begin
						o = '{tts_pkg::KIND_FULL, 32'd0, 1'b1, 1'b0};
					end else begin
						id_counter = id_counter + 32'd1;
						ent_id = {ent_id, id_counter};
						ent_due = {ent_due, w.due_time};
						ent_per = {ent_per, 32'(w.period)};
						o = '{tts_pkg::KIND_ASSIGNED, id_counter, 1'b1, 1'b0};
					end
					r = {r, o};
				end
				tts_pkg::CMD_CLR_ID: begin
					for (int i = 0; i < ent_id.size(); i++)
						if (ent_id[i] != w.target_id) begin
							nid = {nid, ent_id[i]};
							ndue = {ndue, ent_due[i]};
							nper = {nper, ent_per[i]};
						end
					ent_id = nid; ent_due = ndue; ent_per = nper;
					o = '{tts_pkg::KIND_DONE, 32'd0, 1'b1, 1'b0};
					r = {r, o};
				end
				tts_pkg::CMD_CLR_ALL: begin
					ent_id.delete(); ent_due.delete(); ent_per.delete();
					o = '{tts_pkg::KIND_DONE, 32'd0, 1'b1, 1'b0};
					r = {r, o};
				end
				default: begin
					// due check is unsigned; rescheduled entries are not refired
					for (int i = 0; i < ent_id.size(); i++) begin
						keep = 1;
						if (ent_due[i] <= w.now) begin
							o = '{tts_pkg::KIND_FIRED, ent_id[i], 1'b0, 1'b0};
							r = {r, o};
							if (ent_per[i] == 32'd0 || ent_per[i] == 32'hFFFF_FFFF)
								keep = 0;
							else
								ent_due[i] = ent_due[i] + ent_per[i];
						end
						if (keep) begin
							nid = {nid, ent_id[i]};
							ndue = {ndue, ent_due[i]};
							nper = {nper, ent_per[i]};
						end
					end
					ent_id = nid; ent_due = ndue; ent_per = nper;
					o = '{tts_pkg::KIND_DONE, 32'd0, 1'b1, 1'b0};
					r = {r, o};
				end
			endcase
			foreach (r[k]) begin
				r[k].table_empty = (ent_id.size() == 0);
				owed = {owed, r[k]};
			end
		endfunction

		function void check_result(tts_pkg::out_t got);
			tts_pkg::out_t exp_r;
			results_seen++;
			if (got.kind == tts_pkg::KIND_FIRED) fires_seen++;
			if (owed.size() == 0) begin
				$display("%0t: expected no word, actual kind=%0d id=%0h last=%0b empty=%0b",
					$realtime, got.kind, got.timer_id, got.last, got.table_empty);
				errors++;
				return;
			end
			exp_r = owed.pop_front();
			if (got.kind !== exp_r.kind) begin
				$display("%0t: kind expected %0d actual %0d", $realtime, exp_r.kind, got.kind);
				errors++;
			end
			if (got.timer_id !== exp_r.timer_id) begin
				$display("%0t: timer_id expected %0h actual %0h", $realtime,
					exp_r.timer_id, got.timer_id);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$display("%0t: last expected %0b actual %0b", $realtime, exp_r.last, got.last);
				errors++;
			end
			if (got.table_empty !== exp_r.table_empty) begin
				$display("%0t: table_empty expected %0b actual %0b", $realtime,
					exp_r.table_empty, got.table_empty);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tts_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	tts_pkg::out_t out_data;

	timer_table_scheduler u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	timer_scoreboard sb;
	longint cycles;
	bit stim_done;
	int words_sent;
	logic [31:0] clock_now;   // running time for well-formed tick sequences

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Accepted words are noted and results checked at the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready)
			sb.note_command(in_data);
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Mostly short gaps, now and then a long one, sometimes none at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver stalls toggle at the falling edge.
	initial begin
		int g;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			g = pick_gap();
			@(negedge clk);
			if (g > 0) begin
				out_ready <= 0;
				repeat (g) @(negedge clk);
			end
			out_ready <= 1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	// Presents one word and holds it until the block takes it; valid only
	// drops when a gap follows, so back-to-back words keep it high.
	task automatic send_word(tts_pkg::in_t w);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_data <= w;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_cmd(tts_pkg::cmd_t c, logic [31:0] due, logic [31:0] per,
		logic [31:0] t_now, logic [31:0] tid);
		tts_pkg::in_t w;
		w.cmd = c;
		w.due_time = due;
		w.period = per;
		w.now = t_now;
		w.target_id = tid;
		send_word(w);
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom();
	endfunction

	// Random period: mostly small positive, with one-shot and negative cases.
	function automatic logic [31:0] rnd_period();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return rnd32();
			3: return 32'h8000_0000 | rnd32();
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	initial begin
		tts_pkg::in_t junk;
		int pick;
		sb = new();
		cycles = 0;
		stim_done = 0;
		words_sent = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes, every command, special cases.
		send_cmd(tts_pkg::CMD_TICK, rnd32(), rnd32(), 32'd0, rnd32());   // empty table tick
		send_cmd(tts_pkg::CMD_ADD, 32'd0, 32'd0, rnd32(), rnd32());       // one-shot, period 0
		send_cmd(tts_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rnd32(), rnd32()); // -1
		send_cmd(tts_pkg::CMD_ADD, 32'd5, 32'h7FFF_FFFF, rnd32(), rnd32());
		send_cmd(tts_pkg::CMD_ADD, 32'd10, 32'hFFFF_FFFE, rnd32(), rnd32()); // negative periodic
		send_cmd(tts_pkg::CMD_TICK, rnd32(), rnd32(), 32'd20, rnd32());
		send_cmd(tts_pkg::CMD_TICK, rnd32(), rnd32(), 32'hFFFF_FFFF, rnd32());
		send_cmd(tts_pkg::CMD_CLR_ID, rnd32(), rnd32(), rnd32(), 32'hDEAD_0000); // absent id
		send_cmd(tts_pkg::CMD_CLR_ID, rnd32(), rnd32(), rnd32(), 32'd3);
		for (int i = 0; i < 17; i++)                                       // fill, then full
			send_cmd(tts_pkg::CMD_ADD, 32'd1, 32'd1, rnd32(), rnd32());
		send_cmd(tts_pkg::CMD_TICK, rnd32(), rnd32(), 32'd1, rnd32());    // the fifteen new entries fire
		send_cmd(tts_pkg::CMD_CLR_ALL, rnd32(), rnd32(), rnd32(), 32'hFFFF_FFFF);

		// Random: a running clock with adds near it, ticks moving forward,
		// clears of recent ids and some noise.
		clock_now = $urandom_range(0, 1000);
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_cmd(tts_pkg::CMD_ADD, clock_now + $urandom_range(0, 300), rnd_period(),
					rnd32(), rnd32());
			else if (pick < 75) begin
				clock_now = clock_now + $urandom_range(0, 150);
				send_cmd(tts_pkg::CMD_TICK, rnd32(), rnd32(), clock_now, rnd32());
			end else if (pick < 87)
				send_cmd(tts_pkg::CMD_CLR_ID, rnd32(), rnd32(), rnd32(),
					sb.id_counter - $urandom_range(0, 20));
			else if (pick < 90)
				send_cmd(tts_pkg::CMD_CLR_ALL, rnd32(), rnd32(), rnd32(), rnd32());
			else begin
				junk.cmd = tts_pkg::cmd_t'(2'($urandom_range(0, 3)));
				junk.due_time = $urandom();
				junk.period = $urandom();
				junk.now = $urandom();
				junk.target_id = $urandom();
				send_word(junk);
			end
		end
		in_valid <= 0;
		stim_done = 1;
	end

	// End of run: drain, settle, report; or give up at the cycle limit.
	initial begin
		@(posedge arst_n);
		while (!(stim_done && sb.owed.size() == 0) && cycles < CYCLE_LIMIT)
			@(posedge clk);
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				sb.owed.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			repeat (80) @(posedge clk);
			$display("covered %0d command words, %0d results of which %0d timer fires",
				words_sent, sb.results_seen, sb.fires_seen);
			if (sb.errors == 0 && sb.owed.size() == 0)
				$display("SCOREBOARD CLEAN");
			else
				$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
